// ===== hw/rtl/trsf_pkg.sv =====
`default_nettype none

package trsf_pkg;

   // Width of the register index on the configuration port.
   localparam int CSR_IDX_W = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_LEFT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_TOP    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_RIGHT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_BOTTOM = 2'd3;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic load;       // capture the accepted request word
      logic box;        // clipped bounding box and vertex deltas
      logic mul;        // edge function and area products at the row start
      logic edge_calc;  // edge values, area sign, scan init
      logic scan;       // test one pixel and step x
      logic finish;     // update running bounds and load the response
   } cmd_type;

   // Status from the datapath back to the sequencer.
   typedef struct packed {
      logic go;         // row is inside the box and the area is nonzero
      logic last_x;     // current pixel is the right end of the box
      logic rsp_free;   // response register can take a new word
   } status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/trsf_ctrl.sv =====
`default_nettype none

module trsf_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  trsf_pkg::status_type status,
   output trsf_pkg::cmd_type    cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_BOX  = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_EDGE = 3'd3;
   localparam logic [2:0] S_SCAN = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_tready = (state_ff == S_IDLE);

   // Next state and command decode.
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_BOX;
            end
         end
         S_BOX: begin
            cmd.box  = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_EDGE;
         end
         S_EDGE: begin
            cmd.edge_calc = 1'b1;
            state_in      = status.go ? S_SCAN : S_DONE;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (status.last_x) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (status.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/trsf_datapath.sv =====
`default_nettype none

module trsf_datapath #(
   parameter int COORD_BITS = 12,
   parameter int REQ_W      = 88,
   parameter int RSP_W      = 72
) (
   input  wire                            clock,
   input  wire                            reset,
   input  trsf_pkg::cmd_type              cmd,
   output trsf_pkg::status_type           status,
   input  wire  [REQ_W-1:0]               req_tdata,
   input  wire                            req_tuser,
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   output logic [RSP_W-1:0]               rsp_tdata,
   output logic [1:0]                     rsp_tuser,
   input  wire                            csr_we,
   input  wire  [trsf_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire  [COORD_BITS-1:0]          csr_wdata
);

   localparam int CB = COORD_BITS;
   localparam int DW = CB + 1;        // coordinate difference
   localparam int PW = 2 * DW;        // product of two differences
   localparam int EW = 2 * CB + 3;    // edge function value
   localparam logic signed [CB-1:0] COORD_MAX = {1'b0, {(CB-1){1'b1}}};

   // Clip rectangle.
   logic signed [CB-1:0] clip_l_ff, clip_t_ff, clip_r_ff, clip_b_ff;
   logic signed [CB-1:0] clip_l_in, clip_t_in, clip_r_in, clip_b_in;

   // Captured request word.
   logic signed [CB-1:0] ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff, row_ff;
   logic signed [CB-1:0] ax_in, ay_in, bx_in, by_in, cx_in, cy_in, row_in;
   logic                 first_ff, first_in;

   // Clipped box and vertex deltas.
   logic signed [CB-1:0] x0_ff, x1_ff, y0_ff, y1_ff;
   logic signed [CB-1:0] x0_in, x1_in, y0_in, y1_in;
   logic signed [DW-1:0] bc_x_ff, bc_y_ff, ca_x_ff, ca_y_ff, ab_x_ff, ab_y_ff;
   logic signed [DW-1:0] bc_x_in, bc_y_in, ca_x_in, ca_y_in, ab_x_in, ab_y_in;

   // Products at the row start.
   logic signed [PW-1:0] p0a_ff, p0b_ff, p1a_ff, p1b_ff, p2a_ff, p2b_ff;
   logic signed [PW-1:0] pra_ff, prb_ff;
   logic signed [PW-1:0] p0a_in, p0b_in, p1a_in, p1b_in, p2a_in, p2b_in;
   logic signed [PW-1:0] pra_in, prb_in;
   logic                 box_ok_ff, box_ok_in;

   // Scan state.
   logic signed [EW-1:0] w0_ff, w1_ff, w2_ff, w0_in, w1_in, w2_in;
   logic                 area_neg_ff, area_neg_in;
   logic signed [CB-1:0] x_ff, x_in;
   logic                 found_ff, found_in;
   logic signed [CB-1:0] start_ff, end_ff, start_in, end_in;

   // Running bounds.
   logic signed [CB-1:0] acc_l_ff, acc_t_ff, acc_r_ff, acc_b_ff;
   logic signed [CB-1:0] acc_l_in, acc_t_in, acc_r_in, acc_b_in;
   logic                 acc_any_ff, acc_any_in;

   // Response register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]     rsp_data_ff, rsp_data_in;
   logic [1:0]           rsp_user_ff, rsp_user_in;

   // Combinational helpers.
   logic signed [CB-1:0] mnx, mxx, mny, mxy;
   logic signed [EW-1:0] area;
   logic                 in_tri;
   logic signed [CB-1:0] base_l, base_t, base_r, base_b;
   logic                 base_any;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign area = EW'(pra_ff) - EW'(prb_ff);

   assign status.go       = box_ok_ff && (area != '0);
   assign status.last_x   = (x_ff == x1_ff);
   assign status.rsp_free = !rsp_valid_ff || rsp_tready;

   // Configuration writes.
   always_comb begin
      clip_l_in = clip_l_ff;
      clip_t_in = clip_t_ff;
      clip_r_in = clip_r_ff;
      clip_b_in = clip_b_ff;
      if (csr_we) begin
         case (csr_index)
            trsf_pkg::CSR_CLIP_LEFT:   clip_l_in = csr_wdata;
            trsf_pkg::CSR_CLIP_TOP:    clip_t_in = csr_wdata;
            trsf_pkg::CSR_CLIP_RIGHT:  clip_r_in = csr_wdata;
            trsf_pkg::CSR_CLIP_BOTTOM: clip_b_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Request capture.
   always_comb begin
      ax_in    = ax_ff;
      ay_in    = ay_ff;
      bx_in    = bx_ff;
      by_in    = by_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      row_in   = row_ff;
      first_in = first_ff;
      if (cmd.load) begin
         ax_in    = req_tdata[0*CB +: CB];
         ay_in    = req_tdata[1*CB +: CB];
         bx_in    = req_tdata[2*CB +: CB];
         by_in    = req_tdata[3*CB +: CB];
         cx_in    = req_tdata[4*CB +: CB];
         cy_in    = req_tdata[5*CB +: CB];
         row_in   = req_tdata[6*CB +: CB];
         first_in = req_tuser;
      end
   end

   // Bounding box of the three vertices.
   always_comb begin
      mnx = ax_ff;
      mxx = ax_ff;
      mny = ay_ff;
      mxy = ay_ff;
      if (bx_ff < mnx) mnx = bx_ff;
      if (cx_ff < mnx) mnx = cx_ff;
      if (bx_ff > mxx) mxx = bx_ff;
      if (cx_ff > mxx) mxx = cx_ff;
      if (by_ff < mny) mny = by_ff;
      if (cy_ff < mny) mny = cy_ff;
      if (by_ff > mxy) mxy = by_ff;
      if (cy_ff > mxy) mxy = cy_ff;
   end

   // Box clipping and vertex deltas.
   always_comb begin
      x0_in   = x0_ff;
      x1_in   = x1_ff;
      y0_in   = y0_ff;
      y1_in   = y1_ff;
      bc_x_in = bc_x_ff;
      bc_y_in = bc_y_ff;
      ca_x_in = ca_x_ff;
      ca_y_in = ca_y_ff;
      ab_x_in = ab_x_ff;
      ab_y_in = ab_y_ff;
      if (cmd.box) begin
         x0_in   = (mnx < clip_l_ff) ? clip_l_ff : mnx;
         y0_in   = (mny < clip_t_ff) ? clip_t_ff : mny;
         x1_in   = (mxx > clip_r_ff) ? clip_r_ff : mxx;
         y1_in   = (mxy > clip_b_ff) ? clip_b_ff : mxy;
         bc_x_in = DW'(cx_ff) - DW'(bx_ff);
         bc_y_in = DW'(cy_ff) - DW'(by_ff);
         ca_x_in = DW'(ax_ff) - DW'(cx_ff);
         ca_y_in = DW'(ay_ff) - DW'(cy_ff);
         ab_x_in = DW'(bx_ff) - DW'(ax_ff);
         ab_y_in = DW'(by_ff) - DW'(ay_ff);
      end
   end

   // Edge function products at the left end of the row, and the area products.
   always_comb begin
      p0a_in    = p0a_ff;
      p0b_in    = p0b_ff;
      p1a_in    = p1a_ff;
      p1b_in    = p1b_ff;
      p2a_in    = p2a_ff;
      p2b_in    = p2b_ff;
      pra_in    = pra_ff;
      prb_in    = prb_ff;
      box_ok_in = box_ok_ff;
      if (cmd.mul) begin
         p0a_in    = (DW'(x0_ff) - DW'(bx_ff)) * bc_y_ff;
         p0b_in    = (DW'(row_ff) - DW'(by_ff)) * bc_x_ff;
         p1a_in    = (DW'(x0_ff) - DW'(cx_ff)) * ca_y_ff;
         p1b_in    = (DW'(row_ff) - DW'(cy_ff)) * ca_x_ff;
         p2a_in    = (DW'(x0_ff) - DW'(ax_ff)) * ab_y_ff;
         p2b_in    = (DW'(row_ff) - DW'(ay_ff)) * ab_x_ff;
         pra_in    = ca_y_ff * ab_x_ff;
         prb_in    = ca_x_ff * ab_y_ff;
         box_ok_in = (x0_ff <= x1_ff) && (y0_ff <= y1_ff) &&
                     (row_ff >= y0_ff) && (row_ff <= y1_ff);
      end
   end

   // A pixel is inside when all edge values carry the winding's sign or are zero.
   always_comb begin
      if (area_neg_ff) begin
         in_tri = (w0_ff <= 0) && (w1_ff <= 0) && (w2_ff <= 0);
      end else begin
         in_tri = (w0_ff >= 0) && (w1_ff >= 0) && (w2_ff >= 0);
      end
   end

   // Scan setup and one pixel per step.
   always_comb begin
      w0_in       = w0_ff;
      w1_in       = w1_ff;
      w2_in       = w2_ff;
      area_neg_in = area_neg_ff;
      x_in        = x_ff;
      found_in    = found_ff;
      start_in    = start_ff;
      end_in      = end_ff;
      if (cmd.edge_calc) begin
         w0_in       = EW'(p0a_ff) - EW'(p0b_ff);
         w1_in       = EW'(p1a_ff) - EW'(p1b_ff);
         w2_in       = EW'(p2a_ff) - EW'(p2b_ff);
         area_neg_in = area[EW-1];
         x_in        = x0_ff;
         found_in    = 1'b0;
         start_in    = '0;
         end_in      = '0;
      end else if (cmd.scan) begin
         w0_in = w0_ff + EW'(bc_y_ff);
         w1_in = w1_ff + EW'(ca_y_ff);
         w2_in = w2_ff + EW'(ab_y_ff);
         x_in  = x_ff + CB'(1);
         if (in_tri) begin
            if (!found_ff) begin
               start_in = x_ff;
            end
            found_in = 1'b1;
            end_in   = x_ff;
         end
      end
   end

   // Running bounds after the optional clear, then the response word.
   always_comb begin
      base_any = first_ff ? 1'b0 : acc_any_ff;
      base_l   = first_ff ? '0 : acc_l_ff;
      base_t   = first_ff ? '0 : acc_t_ff;
      base_r   = first_ff ? '0 : acc_r_ff;
      base_b   = first_ff ? '0 : acc_b_ff;
      acc_l_in   = acc_l_ff;
      acc_t_in   = acc_t_ff;
      acc_r_in   = acc_r_ff;
      acc_b_in   = acc_b_ff;
      acc_any_in = acc_any_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (cmd.finish) begin
         acc_l_in   = base_l;
         acc_t_in   = base_t;
         acc_r_in   = base_r;
         acc_b_in   = base_b;
         acc_any_in = base_any;
         if (found_ff) begin
            acc_any_in = 1'b1;
            acc_b_in   = row_ff;
            if (!base_any) begin
               acc_l_in = start_ff;
               acc_t_in = row_ff;
               acc_r_in = end_ff;
            end else begin
               if (start_ff < base_l) acc_l_in = start_ff;
               if (end_ff > base_r) acc_r_in = end_ff;
            end
         end
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'({acc_b_in, acc_r_in, acc_t_in, acc_l_in, end_ff, start_ff});
         rsp_user_in  = {acc_any_in, found_ff};
      end
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         clip_l_ff    <= '0;
         clip_t_ff    <= '0;
         clip_r_ff    <= COORD_MAX;
         clip_b_ff    <= COORD_MAX;
         acc_l_ff     <= '0;
         acc_t_ff     <= '0;
         acc_r_ff     <= '0;
         acc_b_ff     <= '0;
         acc_any_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clip_l_ff    <= clip_l_in;
         clip_t_ff    <= clip_t_in;
         clip_r_ff    <= clip_r_in;
         clip_b_ff    <= clip_b_in;
         acc_l_ff     <= acc_l_in;
         acc_t_ff     <= acc_t_in;
         acc_r_ff     <= acc_r_in;
         acc_b_ff     <= acc_b_in;
         acc_any_ff   <= acc_any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      bx_ff       <= bx_in;
      by_ff       <= by_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      row_ff      <= row_in;
      first_ff    <= first_in;
      x0_ff       <= x0_in;
      x1_ff       <= x1_in;
      y0_ff       <= y0_in;
      y1_ff       <= y1_in;
      bc_x_ff     <= bc_x_in;
      bc_y_ff     <= bc_y_in;
      ca_x_ff     <= ca_x_in;
      ca_y_ff     <= ca_y_in;
      ab_x_ff     <= ab_x_in;
      ab_y_ff     <= ab_y_in;
      p0a_ff      <= p0a_in;
      p0b_ff      <= p0b_in;
      p1a_ff      <= p1a_in;
      p1b_ff      <= p1b_in;
      p2a_ff      <= p2a_in;
      p2b_ff      <= p2b_in;
      pra_ff      <= pra_in;
      prb_ff      <= prb_in;
      box_ok_ff   <= box_ok_in;
      w0_ff       <= w0_in;
      w1_ff       <= w1_in;
      w2_ff       <= w2_in;
      area_neg_ff <= area_neg_in;
      x_ff        <= x_in;
      found_ff    <= found_in;
      start_ff    <= start_in;
      end_ff      <= end_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/triangle_row_span_finder.sv =====
// Each word passes the sequencer states box, mul, edge, scan and done; scan tests
// one pixel per cycle and is skipped unless the row is inside the box and the
// area is nonzero. A new word is accepted only after done loads the response.
// A finished response waits in its own register while the next word is accepted.
// Reset (synchronous, active high) clears the running bounds, drops any pending
// response and sets the clip rectangle to 0..2^(COORD_BITS-1)-1 on both axes.
`default_nettype none

module triangle_row_span_finder #(
   parameter int COORD_BITS = 12
) (
   input  wire                            clock,
   input  wire                            reset,
   // Request: vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y, scan_row
   input  wire                            req_tvalid,
   output logic                           req_tready,
   input  wire  [((7*COORD_BITS+7)/8)*8-1:0] req_tdata,
   // first_row
   input  wire                            req_tuser,
   // Response: span_start, span_end, bound_left, bound_top, bound_right, bound_bottom
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   output logic [((6*COORD_BITS+7)/8)*8-1:0] rsp_tdata,
   // span_found, any_filled
   output logic [1:0]                     rsp_tuser,
   input  wire                            csr_we,
   input  wire  [trsf_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire  [COORD_BITS-1:0]          csr_wdata
);

   localparam int CB    = COORD_BITS;
   localparam int REQ_W = ((7*COORD_BITS+7)/8)*8;
   localparam int RSP_W = ((6*COORD_BITS+7)/8)*8;

   trsf_pkg::cmd_type    cmd;
   trsf_pkg::status_type status;

   // Sequencer.
   trsf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Box, edge functions, scan and bounds.
   trsf_datapath #(
      .COORD_BITS (COORD_BITS),
      .REQ_W      (REQ_W),
      .RSP_W      (RSP_W)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // A found span never runs backward.
   a_span_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |->
         ($signed(rsp_tdata[0 +: CB]) <= $signed(rsp_tdata[CB +: CB])))
      else $error("span start lies right of span end");

   // A found span always leaves the running bounds filled.
   a_found_fills: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> rsp_tuser[1])
      else $error("span found without any_filled");

   // Bounds stay zero until some row is filled.
   a_empty_bounds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[1]) |-> (rsp_tdata[2*CB +: 4*CB] == '0))
      else $error("bounds nonzero while nothing is filled");

   // One word at a time: the request side closes right after an accept.
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while a word is in work");

endmodule

`default_nettype wire
